// File: design/twh_pkg.sv
// Shared types, constants and codes of the terrain-weighted wave height block.
// Used by twh_wave and the top level; depends on nothing.
`timescale 1ns / 1ps

package twh_pkg;

  localparam int MAX_WAVES_DEF = 8;
  localparam int GRID_MAX_DEF  = 256;
  localparam int HMAP_DEPTH    = 65536;
  localparam int HMAP_AW       = 16;
  localparam int ACC_W         = 52;
  localparam int TERM_W        = 48;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [16:0] SIN_A          = 17'd102944;
  localparam logic [16:0] SIN_B          = 17'd42047;
  localparam logic [16:0] SIN_C          = 17'd4640;

  localparam logic [3:0]  RST_WAVE_COUNT  = 4'd3;
  localparam logic [31:0] RST_TERRAIN_SIZE = 32'd16777216;
  localparam logic [8:0]  RST_GRID        = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD_HEIGHT = 2'd0,
    OP_LOAD_WAVE   = 2'd1,
    OP_TICK        = 2'd2,
    OP_QUERY       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_WAVE_COUNT  = 3'd0,
    CFG_ORIGIN_X    = 3'd1,
    CFG_ORIGIN_Z    = 3'd2,
    CFG_TERRAIN_SIZE = 3'd3,
    CFG_GRID_X      = 3'd4,
    CFG_GRID_Z      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [15:0]        height_slot;
    logic signed [15:0] height_value;
    logic [2:0]         wave_slot;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_z;
    logic [15:0]        wave_amp;
    logic [17:0]        wave_len;
    logic [15:0]        wave_speed;
    logic [31:0]        time_delta;
  } item_t;

  typedef struct packed {
    logic signed [31:0] offset_y;
    logic               was_query;
  } result_t;

  // One wave table entry as held in the wave memory.
  typedef struct packed {
    logic [31:0]        wnum;
    logic [15:0]        speed;
    logic [15:0]        amp;
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_x;
  } wave_t;

  // Handshake between the sequencer and the per-wave term unit.
  typedef struct packed {
    logic                      done;
    logic signed [TERM_W-1:0]  term;
  } wave_res_t;

endpackage

// File: design/twh_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module twh_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/twh_div.sv
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// The caller guarantees the quotient fits in 32 bits. Depends on nothing.
`timescale 1ns / 1ps

module twh_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [34:0] rem_q, rem_d;
  logic [31:0] sh_q, sh_d;
  logic [33:0] div_q, div_d;
  logic [34:0] trial;
  logic        ge;

  always_comb begin
    trial  = {rem_q[33:0], sh_q[31]};
    ge     = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {3'b0, dividend_i[63:32]};
      sh_d   = dividend_i[31:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (trial - {1'b0, div_q}) : trial;
      sh_d  = {sh_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: design/twh_wave.sv
// Per-wave term unit: phase, quintic sine and amp*height*sine through one
// shared 33x33 signed multiplier, one product per cycle. Depends on twh_pkg.
`timescale 1ns / 1ps

module twh_wave (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  twh_pkg::wave_t      wave_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic [31:0]         time_i,
  input  logic signed [15:0]  height_i,
  output twh_pkg::wave_res_t  res_o
);
  import twh_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_DX   = 14'b00000000000010,
    ST_DZ   = 14'b00000000000100,
    ST_PLO  = 14'b00000000001000,
    ST_PHI  = 14'b00000000010000,
    ST_ST   = 14'b00000000100000,
    ST_TLO  = 14'b00000001000000,
    ST_THI  = 14'b00000010000000,
    ST_X2   = 14'b00000100000000,
    ST_T1   = 14'b00001000000000,
    ST_T2   = 14'b00010000000000,
    ST_Y    = 14'b00100000000000,
    ST_AH   = 14'b01000000000000,
    ST_TERM = 14'b10000000000000
  } st_e;

  st_e state_q, state_d;
  logic done_q;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  logic signed [48:0] dot_q;
  logic [63:0]        plo_q;
  logic [31:0]        ps_q;
  logic [47:0]        st_q;
  logic [63:0]        tlo_q;
  logic [31:0]        ph_q;
  logic [16:0]        x_q, x2_q, t_q;
  logic signed [15:0] sin_q;
  logic signed [32:0] ah_q;
  logic signed [TERM_W-1:0] term_q;

  logic [16:0] x_c;
  logic [63:0] phi_sum, thi_sum;
  logic [31:0] pt_c;
  logic [16:0] y17;
  logic [15:0] y_cap;

  // Fold the phase into the first quarter turn.
  assign x_c = ph_q[30] ? (17'd65536 - {1'b0, ph_q[29:14]}) : {1'b0, ph_q[29:14]};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      ST_DX:   begin ma = 33'(wave_i.dir_x);          mb = 33'(pos_x_i); end
      ST_DZ:   begin ma = 33'(wave_i.dir_z);          mb = 33'(pos_z_i); end
      ST_PLO:  begin ma = {1'b0, dot_q[31:0]};        mb = {1'b0, wave_i.wnum}; end
      ST_PHI:  begin ma = 33'($signed(dot_q[48:32])); mb = {1'b0, wave_i.wnum}; end
      ST_ST:   begin ma = {17'b0, wave_i.speed};      mb = {1'b0, time_i}; end
      ST_TLO:  begin ma = {1'b0, st_q[31:0]};         mb = {1'b0, INV_TWO_PI_Q32}; end
      ST_THI:  begin ma = {17'b0, st_q[47:32]};       mb = {1'b0, INV_TWO_PI_Q32}; end
      ST_X2:   begin ma = {16'b0, x_c};               mb = {16'b0, x_c}; end
      ST_T1:   begin ma = {16'b0, SIN_C};             mb = {16'b0, x2_q}; end
      ST_T2:   begin ma = {16'b0, t_q};               mb = {16'b0, x2_q}; end
      ST_Y:    begin ma = {16'b0, t_q};               mb = {16'b0, x_q}; end
      ST_AH:   begin ma = {17'b0, wave_i.amp};        mb = 33'(height_i); end
      ST_TERM: begin ma = ah_q;                       mb = 33'(sin_q); end
      default: begin ma = '0;                         mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  // Wrapped 64-bit phase products assembled from the two partial products.
  assign phi_sum = plo_q + {prod[31:0], 32'b0};
  assign thi_sum = tlo_q + {prod[31:0], 32'b0};
  assign pt_c    = thi_sum[55:24];
  assign y17     = prod[33:17];
  assign y_cap   = (y17 > 17'd32767) ? 16'd32767 : y17[15:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_DX;
      ST_DX:   state_d = ST_DZ;
      ST_DZ:   state_d = ST_PLO;
      ST_PLO:  state_d = ST_PHI;
      ST_PHI:  state_d = ST_ST;
      ST_ST:   state_d = ST_TLO;
      ST_TLO:  state_d = ST_THI;
      ST_THI:  state_d = ST_X2;
      ST_X2:   state_d = ST_T1;
      ST_T1:   state_d = ST_T2;
      ST_T2:   state_d = ST_Y;
      ST_Y:    state_d = ST_AH;
      ST_AH:   state_d = ST_TERM;
      ST_TERM: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_TERM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DX)   dot_q  <= prod[48:0];
    if (state_q == ST_DZ)   dot_q  <= dot_q + prod[48:0];
    if (state_q == ST_PLO)  plo_q  <= prod[63:0];
    if (state_q == ST_PHI)  ps_q   <= phi_sum[58:27];
    if (state_q == ST_ST)   st_q   <= prod[47:0];
    if (state_q == ST_TLO)  tlo_q  <= prod[63:0];
    if (state_q == ST_THI)  ph_q   <= ps_q - pt_c;
    if (state_q == ST_X2) begin
      x_q  <= x_c;
      x2_q <= prod[32:16];
    end
    if (state_q == ST_T1)   t_q    <= SIN_B - prod[32:16];
    if (state_q == ST_T2)   t_q    <= SIN_A - prod[32:16];
    if (state_q == ST_Y)    sin_q  <= ph_q[31] ? -$signed(y_cap) : $signed(y_cap);
    if (state_q == ST_AH)   ah_q   <= prod[32:0];
    if (state_q == ST_TERM) term_q <= prod[TERM_W-1:0];
  end

  assign res_o.done = done_q;
  assign res_o.term = term_q;

endmodule

// File: design/terrain_weighted_wave_height.sv
// Top level of the terrain-weighted wave height block: sequencer, registers,
// height map and wave memories. Depends on twh_pkg, twh_ram, twh_div, twh_wave.
`timescale 1ns / 1ps

// Usage. An item is accepted on a rising edge with start_i high and busy_o
// low; the block then works on that one item and takes no other until done.
// Every item gives exactly one result beat: res_valid_o is high for one cycle
// with res_o, and the receiver must take it then, since it cannot stall.
// busy_o falls in the same cycle as the result shows, so the next item can
// be started while the result is on the ports.
// A height load or a tick finishes in its dispatch state. A wave load
// finishes there too for a wavelength of 16 or less; otherwise it waits on
// the shared 32-step restoring divider that forms the wavenumber. In a
// query, two divider passes map the position to the grid (an axis that
// clamps skips its pass); then, for each active wave, a wave memory read and
// a start come before the per-wave unit works through its single shared
// multiplier and signals done.
// The configuration channel is always ready and its beats are taken on any
// cycle; write it only while the block is idle.
// Reset clears the elapsed time and sets the registers to their defaults.
// Height map and wave memory contents are undefined until loaded, and no
// clearing pass runs.

module terrain_weighted_wave_height #(
  parameter int MaxWaves = twh_pkg::MAX_WAVES_DEF,
  parameter int GridMax  = twh_pkg::GRID_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  twh_pkg::item_t   item_i,
  output logic             res_valid_o,
  output twh_pkg::result_t res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import twh_pkg::*;

  localparam int WAW = (MaxWaves > 1) ? $clog2(MaxWaves) : 1;
  localparam int NW  = $clog2(MaxWaves + 1);
  localparam int GW  = $clog2(GridMax + 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_WDIV     = 11'b00000000100,
    S_GMUL     = 11'b00000001000,
    S_GSTART   = 11'b00000010000,
    S_GDIV     = 11'b00000100000,
    S_HADDR    = 11'b00001000000,
    S_HWAIT    = 11'b00010000000,
    S_WRD      = 11'b00100000000,
    S_WRUN     = 11'b01000000000,
    S_FINAL    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [3:0]  wave_count_q;
  logic [31:0] origin_x_q, origin_z_q, size_q;
  logic [8:0]  grid_x_q, grid_z_q;
  logic [31:0] time_q;

  // Item and working registers.
  item_t              item_q;
  logic signed [34:0] nx_q, nz_q;
  logic               axis_q;
  logic [63:0]        mprod_q;
  logic [GW-1:0]      ix_q, iz_q;
  logic [NW-1:0]      idx_q;
  logic signed [ACC_W-1:0] acc_q;
  logic               res_valid_q;
  result_t            res_q;

  // Derived values.
  logic [GW-1:0]      gx, gz, g1;
  logic [NW-1:0]      n_eff;
  logic signed [32:0] dx33, dz33;
  logic signed [34:0] nx_c, nz_c, num_sel;
  logic signed [34:0] den_s;
  logic               num_low, num_high;
  logic [31:0]        cell_lin;
  logic               finish;
  result_t            fin_res;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] acc_div;
  logic signed [31:0] offset_c;
  logic               slot_ok;

  // Memories and shared units.
  logic               hm_we, hm_re;
  logic [HMAP_AW-1:0] hm_raddr;
  logic [15:0]        hm_rdata;
  logic               wv_we, wv_re;
  logic [WAW-1:0]     wv_waddr;
  wave_t              wv_wdata, wv_rdata;
  logic [31:0]        wnum_new;
  logic               div_start, div_done;
  logic [63:0]        div_dividend;
  logic [33:0]        div_divisor;
  logic [31:0]        div_quot;
  logic               wv_start;
  wave_res_t          wv_res;

  // Grid sizes clamped to 2..GridMax and the active wave count.
  always_comb begin
    if (grid_x_q < 9'd2)                 gx = GW'(2);
    else if (int'(grid_x_q) > GridMax)   gx = GW'(GridMax);
    else                                 gx = GW'(grid_x_q);
    if (grid_z_q < 9'd2)                 gz = GW'(2);
    else if (int'(grid_z_q) > GridMax)   gz = GW'(GridMax);
    else                                 gz = GW'(grid_z_q);
    if (int'(wave_count_q) > MaxWaves)   n_eff = NW'(MaxWaves);
    else                                 n_eff = NW'(wave_count_q);
  end

  // The uv mapping is done on integers: u = num / den with den = 2 * size.
  assign dx33  = 33'(item_q.pos_x) - 33'($signed(origin_x_q));
  assign dz33  = 33'(item_q.pos_z) - 33'($signed(origin_z_q));
  assign nx_c  = {dx33[32], dx33, 1'b0} + $signed({3'b0, size_q});
  assign nz_c  = $signed({3'b0, size_q}) - {dz33[32], dz33, 1'b0};
  assign den_s = $signed({2'b0, size_q, 1'b0});

  assign num_sel  = axis_q ? nz_q : nx_q;
  assign g1       = (axis_q ? gz : gx) - GW'(1);
  assign num_low  = num_sel[34] || (num_sel == '0);
  assign num_high = !num_low && (num_sel >= den_s);

  assign cell_lin = 32'(iz_q) * 32'(gx) + 32'(ix_q);
  assign slot_ok  = int'(item_q.wave_slot) < MaxWaves;

  // Wavenumber 1/len in Q4.28, rounded; short wavelengths saturate.
  assign wnum_new = (item_q.wave_len <= 18'd16) ? 32'hFFFF_FFFF : div_quot;

  assign div_start    = (state_q == S_GSTART) ||
                        ((state_q == S_DISPATCH) && (item_q.op == OP_LOAD_WAVE) &&
                         (item_q.wave_len > 18'd16));
  assign div_dividend = (state_q == S_DISPATCH) ?
                        ((64'd1 << 36) + 64'(item_q.wave_len[17:1])) : mprod_q;
  assign div_divisor  = (state_q == S_DISPATCH) ? {16'b0, item_q.wave_len} :
                        {1'b0, size_q, 1'b0};

  // Final scaling: divide by 32768 toward zero, then saturate to 32 bits.
  assign acc_adj = acc_q[ACC_W-1] ? (acc_q + ACC_W'(32767)) : acc_q;
  assign acc_div = acc_adj >>> 15;
  always_comb begin
    if (acc_div > ACC_W'(64'sd2147483647))       offset_c = 32'sh7FFF_FFFF;
    else if (acc_div < -ACC_W'(64'sd2147483648)) offset_c = 32'sh8000_0000;
    else                                         offset_c = acc_div[31:0];
  end

  // Main sequencer.
  always_comb begin
    state_d  = state_q;
    finish   = 1'b0;
    fin_res  = '0;
    hm_we    = 1'b0;
    hm_re    = 1'b0;
    wv_we    = 1'b0;
    wv_re    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (item_q.op)
          OP_LOAD_HEIGHT: begin
            hm_we  = 1'b1;
            finish = 1'b1;
          end
          OP_LOAD_WAVE: begin
            if (item_q.wave_len <= 18'd16) begin
              wv_we  = slot_ok;
              finish = 1'b1;
            end else begin
              state_d = S_WDIV;
            end
          end
          OP_TICK: finish = 1'b1;
          OP_QUERY: state_d = S_GMUL;
          default: finish = 1'b1;
        endcase
      end
      S_WDIV: begin
        if (div_done) begin
          wv_we  = slot_ok;
          finish = 1'b1;
        end
      end
      S_GMUL: begin
        if (num_low || num_high) begin
          state_d = axis_q ? S_HADDR : S_GMUL;
        end else begin
          state_d = S_GSTART;
        end
      end
      S_GSTART: state_d = S_GDIV;
      S_GDIV: begin
        if (div_done) state_d = axis_q ? S_HADDR : S_GMUL;
      end
      S_HADDR: begin
        hm_re   = 1'b1;
        state_d = S_HWAIT;
      end
      S_HWAIT: begin
        state_d = (n_eff == '0) ? S_FINAL : S_WRD;
      end
      S_WRD: begin
        wv_re   = 1'b1;
        state_d = S_WRUN;
      end
      S_WRUN: begin
        // Wave memory data is valid from the first cycle here and holds.
        if (wv_res.done) begin
          state_d = ((idx_q + NW'(1)) == n_eff) ? S_FINAL : S_WRD;
        end
      end
      S_FINAL: begin
        finish            = 1'b1;
        fin_res.offset_y  = offset_c;
        fin_res.was_query = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
    if (finish) state_d = S_IDLE;
  end

  // The term unit is started on the cycle after the wave read is issued.
  logic wv_pending_q;
  assign wv_start = wv_pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_valid_q  <= 1'b0;
      wv_pending_q <= 1'b0;
      axis_q       <= 1'b0;
      time_q       <= '0;
      wave_count_q <= RST_WAVE_COUNT;
      origin_x_q   <= '0;
      origin_z_q   <= '0;
      size_q       <= RST_TERRAIN_SIZE;
      grid_x_q     <= RST_GRID;
      grid_z_q     <= RST_GRID;
    end else begin
      state_q      <= state_d;
      res_valid_q  <= finish;
      wv_pending_q <= wv_re;
      if (state_q == S_DISPATCH) begin
        axis_q <= 1'b0;
      end else if (((state_q == S_GMUL) && (num_low || num_high)) ||
                   ((state_q == S_GDIV) && div_done)) begin
        axis_q <= 1'b1;
      end
      if ((state_q == S_DISPATCH) && (item_q.op == OP_TICK)) begin
        time_q <= time_q + item_q.time_delta;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WAVE_COUNT:   wave_count_q <= cfg_data_i[3:0];
          CFG_ORIGIN_X:     origin_x_q   <= cfg_data_i;
          CFG_ORIGIN_Z:     origin_z_q   <= cfg_data_i;
          CFG_TERRAIN_SIZE: size_q       <= cfg_data_i;
          CFG_GRID_X:       grid_x_q     <= cfg_data_i[8:0];
          CFG_GRID_Z:       grid_z_q     <= cfg_data_i[8:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start_i) item_q <= item_i;
    if (state_q == S_DISPATCH) begin
      nx_q <= nx_c;
      nz_q <= nz_c;
    end
    if (state_q == S_GMUL) begin
      mprod_q <= 64'(num_sel[32:0]) * 64'(g1);
      if (num_low || num_high) begin
        if (axis_q) iz_q <= num_high ? g1 : '0;
        else        ix_q <= num_high ? g1 : '0;
      end
    end
    if ((state_q == S_GDIV) && div_done) begin
      if (axis_q) iz_q <= GW'(div_quot);
      else        ix_q <= GW'(div_quot);
    end
    if (state_q == S_HWAIT) begin
      idx_q <= '0;
      acc_q <= '0;
    end
    if ((state_q == S_WRUN) && wv_res.done) begin
      idx_q <= idx_q + NW'(1);
      acc_q <= acc_q + ACC_W'(wv_res.term);
    end
    if (finish) res_q <= fin_res;
  end

  assign hm_raddr = cell_lin[HMAP_AW-1:0];
  assign wv_waddr = WAW'(item_q.wave_slot);

  assign wv_wdata.wnum  = wnum_new;
  assign wv_wdata.speed = item_q.wave_speed;
  assign wv_wdata.amp   = item_q.wave_amp;
  assign wv_wdata.dir_z = item_q.dir_z;
  assign wv_wdata.dir_x = item_q.dir_x;

  twh_ram #(
    .Width(16),
    .Depth(HMAP_DEPTH)
  ) u_hmap (
    .clk_i  (clk_i),
    .we_i   (hm_we),
    .waddr_i(item_q.height_slot),
    .wdata_i(item_q.height_value),
    .re_i   (hm_re),
    .raddr_i(hm_raddr),
    .rdata_o(hm_rdata)
  );

  twh_ram #(
    .Width($bits(wave_t)),
    .Depth(MaxWaves)
  ) u_waves (
    .clk_i  (clk_i),
    .we_i   (wv_we),
    .waddr_i(wv_waddr),
    .wdata_i(wv_wdata),
    .re_i   (wv_re),
    .raddr_i(WAW'(idx_q)),
    .rdata_o(wv_rdata)
  );

  twh_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  twh_wave u_wave (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wv_start),
    .wave_i  (wv_rdata),
    .pos_x_i (item_q.pos_x),
    .pos_z_i (item_q.pos_z),
    .time_i  (time_q),
    .height_i($signed(hm_rdata)),
    .res_o   (wv_res)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

`ifndef NO_ASSERTIONS
  // Every item passes through the dispatch state after it is accepted, so result beats never abut.
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result beats back to back");

  // An accepted item always makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start work");

  // The block only goes idle by delivering a result.
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o)
    else $error("work ended without a result");

  // Results that do not answer a query carry a zero offset.
  a_nonquery_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.was_query) |-> (res_o.offset_y == 32'sd0))
    else $error("non-query result with nonzero offset");
`endif

endmodule
